// ===== sv/length_prefixed_packet_deframer_unit_macros.svh =====
// Assertion macros for the length-prefixed packet deframer.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LPPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LPPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lppd_pkg.sv =====
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package lppd_pkg;

    localparam int MAX_PACKET  = 64;
    localparam int ADDR_W      = $clog2(MAX_PACKET);
    localparam int LEN_W       = $clog2(MAX_PACKET + 1);
    localparam int CNT_W       = 9;
    localparam int POS_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [7:0] END_MARK       = 8'h16;
    localparam logic [7:0] OK_CODE_RST    = 8'd254;
    localparam logic [7:0] EXT_CODE_RST   = 8'd121;
    localparam logic [CNT_W-1:0] OK_LEN      = CNT_W'(2);
    localparam logic [CNT_W-1:0] EXT_LEN     = CNT_W'(4);
    localparam logic [CNT_W-1:0] OTHER_LEN   = CNT_W'(1);
    localparam logic [CNT_W-1:0] EXT_LEN_POS = CNT_W'(2);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_GAP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OK_TYPE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EXT_TYPE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_END  = 2'd1,
        ST_OVERSIZE = 2'd2,
        ST_GAP      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_LOAD
    } back_state_t;

    // One entry of the front-to-back queue: a buffered run or a single status.
    typedef struct packed {
        logic             is_run;
        status_t          code;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

endpackage

`default_nettype wire

// ===== sv/lppd_front.sv =====
// Front end: accepts bytes and gap events, tracks packet length, fills the store.
// Depends on lppd_pkg; pushes commands into lppd_queue.
`default_nettype none

module lppd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire logic [7:0]           byte_value,
    input  wire logic [7:0]           ok_code,
    input  wire logic [7:0]           ext_code,
    input  wire logic                 q_full,
    output logic                      q_push,
    output lppd_pkg::cmd_t            q_cmd,
    input  wire logic                 run_done,
    output lppd_pkg::wr_t             mem_wr
);

    logic [lppd_pkg::CNT_W-1:0] seen_reg, seen_next;
    logic [lppd_pkg::CNT_W-1:0] exp_reg, exp_next;
    logic [7:0]                 first_reg, first_next;
    logic                       pending_reg, pending_next;

    logic                       accept;
    logic [7:0]                 first_b;
    logic                       ok_first, ext_first, ext_stored;
    logic [lppd_pkg::CNT_W-1:0] exp_now, seen_inc;
    logic                       complete;

    assign in_ready = !pending_reg && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        first_b    = (seen_reg == '0) ? byte_value : first_reg;
        ok_first   = (first_b == ok_code);
        ext_first  = (first_b == ext_code) && !ok_first;
        ext_stored = (first_reg == ext_code) && (first_reg != ok_code);

        if (seen_reg == '0)
        begin
            exp_now = ok_first ? lppd_pkg::OK_LEN
                    : (ext_first ? lppd_pkg::EXT_LEN : lppd_pkg::OTHER_LEN);
        end
        else if (seen_reg == lppd_pkg::EXT_LEN_POS && ext_stored)
        begin
            exp_now = exp_reg + {{(lppd_pkg::CNT_W-8){1'b0}}, byte_value};
        end
        else
        begin
            exp_now = exp_reg;
        end

        seen_inc = seen_reg + 1'b1;
        complete = (seen_inc == exp_now);
    end

    always_comb
    begin
        seen_next    = seen_reg;
        exp_next     = exp_reg;
        first_next   = first_reg;
        pending_next = pending_reg;
        q_push       = 1'b0;
        q_cmd        = '0;
        mem_wr.en    = 1'b0;
        mem_wr.addr  = seen_reg[lppd_pkg::ADDR_W-1:0];
        mem_wr.data  = byte_value;

        if (accept)
        begin
            if (operation == lppd_pkg::OP_GAP)
            begin
                if (seen_reg != '0)
                begin
                    q_push      = 1'b1;
                    q_cmd.code  = lppd_pkg::ST_GAP;
                end
                seen_next = '0;
                exp_next  = '0;
            end
            else
            begin
                mem_wr.en  = (seen_reg < lppd_pkg::CNT_W'(lppd_pkg::MAX_PACKET));
                first_next = first_b;
                if (complete)
                begin
                    q_push = 1'b1;
                    if (seen_inc > lppd_pkg::CNT_W'(lppd_pkg::MAX_PACKET))
                    begin
                        q_cmd.code = lppd_pkg::ST_OVERSIZE;
                    end
                    else if (ext_first && byte_value != lppd_pkg::END_MARK)
                    begin
                        q_cmd.code = lppd_pkg::ST_BAD_END;
                    end
                    else
                    begin
                        q_cmd.is_run = 1'b1;
                        q_cmd.code   = lppd_pkg::ST_GOOD;
                        q_cmd.len    = seen_inc[lppd_pkg::LEN_W-1:0];
                        pending_next = 1'b1;
                    end
                    seen_next = '0;
                    exp_next  = '0;
                end
                else
                begin
                    seen_next = seen_inc;
                    exp_next  = exp_now;
                end
            end
        end

        if (run_done)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            exp_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            seen_reg    <= seen_next;
            exp_reg     <= exp_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

// ===== sv/lppd_queue.sv =====
// Short command queue between front and back ends.
// Depends on lppd_pkg for the entry type and depth.
`default_nettype none

module lppd_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  lppd_pkg::cmd_t push_cmd,
    output logic           full,
    input  wire logic      pop,
    output lppd_pkg::cmd_t pop_cmd,
    output logic           valid
);

    localparam int PTR_W = (lppd_pkg::QUEUE_DEPTH > 1) ? $clog2(lppd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lppd_pkg::QUEUE_DEPTH + 1);

    lppd_pkg::cmd_t   entry_reg [lppd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(lppd_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lppd_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lppd_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lppd_back.sv =====
// Back end: owns the packet store, replays buffered runs and emits status transactions.
// Depends on lppd_pkg and the assertion macro header.
`default_nettype none
`include "length_prefixed_packet_deframer_unit_macros.svh"

module lppd_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  lppd_pkg::wr_t                    mem_wr,
    input  wire logic                        q_valid,
    input  lppd_pkg::cmd_t                   q_cmd,
    output logic                             q_pop,
    output logic                             run_done,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [7:0]                       data_byte,
    output logic [lppd_pkg::POS_W-1:0]       byte_position,
    output logic                             last_of_run,
    output logic [1:0]                       status
);

    logic [7:0] mem [lppd_pkg::MAX_PACKET];
    logic [7:0] rd_data_reg;

    lppd_pkg::back_state_t        state_reg, state_next;
    logic [lppd_pkg::ADDR_W-1:0]  idx_reg, idx_next;
    logic [lppd_pkg::LEN_W-1:0]   len_reg, len_next;

    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   data_reg, data_next;
    logic [lppd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         last_reg, last_next;
    lppd_pkg::status_t            status_reg, status_next;

    logic out_free, at_last, load_status, load_byte;

    assign out_free = !out_valid_reg || out_ready;
    assign at_last  = ((lppd_pkg::LEN_W'(idx_reg) + 1'b1) == len_reg);

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lppd_pkg::BK_IDLE:
            begin
                if (q_valid && q_cmd.is_run)
                begin
                    state_next = lppd_pkg::BK_FETCH;
                end
            end
            lppd_pkg::BK_FETCH:
            begin
                state_next = lppd_pkg::BK_LOAD;
            end
            lppd_pkg::BK_LOAD:
            begin
                if (out_free)
                begin
                    state_next = at_last ? lppd_pkg::BK_IDLE : lppd_pkg::BK_FETCH;
                end
            end
            default:
            begin
                state_next = lppd_pkg::BK_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop       = 1'b0;
        load_status = 1'b0;
        load_byte   = 1'b0;
        run_done    = 1'b0;
        unique case (state_reg)
            lppd_pkg::BK_IDLE:
            begin
                if (q_valid && q_cmd.is_run)
                begin
                    q_pop = 1'b1;
                end
                else if (q_valid && out_free)
                begin
                    q_pop       = 1'b1;
                    load_status = 1'b1;
                end
            end
            lppd_pkg::BK_FETCH:
            begin
            end
            lppd_pkg::BK_LOAD:
            begin
                load_byte = out_free;
                run_done  = out_free && at_last;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        data_next      = data_reg;
        pos_next       = pos_reg;
        last_next      = last_reg;
        status_next    = status_reg;

        if (q_pop && q_cmd.is_run)
        begin
            idx_next = '0;
            len_next = q_cmd.len;
        end
        if (load_status)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            pos_next       = '0;
            last_next      = 1'b1;
            status_next    = q_cmd.code;
        end
        if (load_byte)
        begin
            out_valid_next = 1'b1;
            data_next      = rd_data_reg;
            pos_next       = lppd_pkg::POS_W'(idx_reg);
            last_next      = at_last;
            status_next    = lppd_pkg::ST_GOOD;
            idx_next       = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lppd_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        data_reg   <= data_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_reg;
    assign byte_position = pos_reg;
    assign last_of_run   = last_reg;
    assign status        = status_reg;

    `LPPD_ASSERT_NOW(a_no_write_during_run, mem_wr.en, state_reg == lppd_pkg::BK_IDLE, "store written while a run is replayed")
    `LPPD_ASSERT_NOW(a_status_is_last, out_valid_reg && status_reg != lppd_pkg::ST_GOOD, last_reg, "status transaction not marked last")
    `LPPD_ASSERT_NEXT(a_fetch_then_load, state_reg == lppd_pkg::BK_FETCH, state_reg == lppd_pkg::BK_LOAD, "fetch not followed by load")

endmodule

`default_nettype wire

// ===== sv/length_prefixed_packet_deframer_unit.sv =====
// A status transaction passes from the byte or gap that causes it through the command
// queue into the output register. A good packet is queued as a run and popped in idle;
// each byte is then read from the store in fetch and presented in load while the receiver
// is ready. Throughput: one input byte per cycle inside a packet while the command queue
// is not full; input is held off while a good packet is replayed from the packet store.
// Reset (rst_n, async, active low) clears counters, queue and output valid, loads type
// codes 254/121; the packet store is not cleared and needs no clearing pass.
`default_nettype none

module length_prefixed_packet_deframer_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             operation,
    input  wire logic [7:0]                       byte_value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [7:0]                            data_byte,
    output logic [lppd_pkg::POS_W-1:0]            byte_position,
    output logic                                  last_of_run,
    output logic [1:0]                            status,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lppd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    logic [7:0]     ok_code_reg;
    logic [7:0]     ext_code_reg;
    logic           q_push, q_full, q_pop, q_valid, run_done;
    lppd_pkg::cmd_t push_cmd, pop_cmd;
    lppd_pkg::wr_t  mem_wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_code_reg  <= lppd_pkg::OK_CODE_RST;
            ext_code_reg <= lppd_pkg::EXT_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lppd_pkg::CFG_OK_TYPE:  ok_code_reg  <= cfg_data;
                lppd_pkg::CFG_EXT_TYPE: ext_code_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    lppd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .byte_value (byte_value),
        .ok_code    (ok_code_reg),
        .ext_code   (ext_code_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .run_done   (run_done),
        .mem_wr     (mem_wr)
    );

    lppd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .valid    (q_valid)
    );

    lppd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .mem_wr        (mem_wr),
        .q_valid       (q_valid),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .run_done      (run_done),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .byte_position (byte_position),
        .last_of_run   (last_of_run),
        .status        (status)
    );

endmodule

`default_nettype wire
